[rtl/blg_pkg.sv]
// Shared types and constants for the line pixel generator.
package blg_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int ERR_WIDTH   = COORD_WIDTH + 2;
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    typedef logic [COORD_WIDTH-1:0] t_coord;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode opcode;
        t_coord  x_start;
        t_coord  y_start;
        t_coord  x_end;
        t_coord  y_end;
    } t_in_word;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } t_out_word;

    // Classified command handed from front to back.
    typedef struct packed {
        logic   is_start;
        t_coord dmaj;
        t_coord dmin;
        logic   x_neg;
        logic   y_neg;
        logic   x_major;
        t_coord xs;
        t_coord ys;
    } t_cmd;

endpackage

[rtl/blg_front.sv]
// Front end: classifies an incoming word and works out deltas, directions and major axis.
module blg_front import blg_pkg::*; (
    input  t_in_word i_word,
    output t_cmd     o_cmd
);

    t_coord dx;
    t_coord dy;
    logic   x_neg;
    logic   y_neg;
    logic   x_major;

    always_comb begin
        x_neg   = i_word.x_end < i_word.x_start;
        y_neg   = i_word.y_end < i_word.y_start;
        dx      = x_neg ? (i_word.x_start - i_word.x_end) : (i_word.x_end - i_word.x_start);
        dy      = y_neg ? (i_word.y_start - i_word.y_end) : (i_word.y_end - i_word.y_start);
        // a tie goes to the y axis
        x_major = dx > dy;

        o_cmd.is_start = (i_word.opcode == OP_START);
        o_cmd.dmaj     = x_major ? dx : dy;
        o_cmd.dmin     = x_major ? dy : dx;
        o_cmd.x_neg    = x_neg;
        o_cmd.y_neg    = y_neg;
        o_cmd.x_major  = x_major;
        o_cmd.xs       = i_word.x_start;
        o_cmd.ys       = i_word.y_start;
    end

endmodule

[rtl/blg_cmd_fifo.sv]
// Short command queue between front and back.
module blg_cmd_fifo import blg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count overflow");

endmodule

[rtl/blg_back.sv]
// Back end: Bresenham stepper holding the line state, with the result register.
module blg_back import blg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_word
);

    t_coord                 r_cur_x,   n_cur_x;
    t_coord                 r_cur_y,   n_cur_y;
    logic [ERR_WIDTH-1:0]   r_err,     n_err;
    logic [ERR_WIDTH-1:0]   r_diag,    n_diag;
    logic [ERR_WIDTH-1:0]   r_axial,   n_axial;
    t_coord                 r_steps,   n_steps;
    logic                   r_x_neg,   n_x_neg;
    logic                   r_y_neg,   n_y_neg;
    logic                   r_x_major, n_x_major;
    logic                   r_active,  n_active;
    logic                   r_out_valid;
    t_out_word              r_out,     n_out;
    logic                   take;
    logic                   err_nonneg;
    logic [ERR_WIDTH-1:0]   dmin2;

    function automatic t_coord move_coord(t_coord c, logic neg);
        return neg ? (c - 1'b1) : (c + 1'b1);
    endfunction

    // a command is taken when the result slot is free or being emptied
    assign take      = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = take;
    assign o_empty   = !r_out_valid;
    assign o_word    = r_out;

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_err      = r_err;
        n_diag     = r_diag;
        n_axial    = r_axial;
        n_steps    = r_steps;
        n_x_neg    = r_x_neg;
        n_y_neg    = r_y_neg;
        n_x_major  = r_x_major;
        n_active   = r_active;
        n_out      = '0;
        err_nonneg = !r_err[ERR_WIDTH-1];
        dmin2      = {1'b0, i_cmd.dmin, 1'b0};

        if (i_cmd.is_start) begin
            n_cur_x   = i_cmd.xs;
            n_cur_y   = i_cmd.ys;
            n_err     = dmin2 - {2'b00, i_cmd.dmaj};
            n_diag    = dmin2 - {1'b0, i_cmd.dmaj, 1'b0};
            n_axial   = dmin2;
            n_steps   = i_cmd.dmaj;
            n_x_neg   = i_cmd.x_neg;
            n_y_neg   = i_cmd.y_neg;
            n_x_major = i_cmd.x_major;
            n_active  = (i_cmd.dmaj != '0);
            n_out.pixel_x     = i_cmd.xs;
            n_out.pixel_y     = i_cmd.ys;
            n_out.pixel_valid = 1'b1;
            n_out.last_pixel  = (i_cmd.dmaj == '0);
        end else if (r_active) begin
            // major axis always moves, minor axis on a non-negative error
            if (r_x_major || err_nonneg) begin
                n_cur_x = move_coord(r_cur_x, r_x_neg);
            end
            if (!r_x_major || err_nonneg) begin
                n_cur_y = move_coord(r_cur_y, r_y_neg);
            end
            n_err    = r_err + (err_nonneg ? r_diag : r_axial);
            n_steps  = r_steps - 1'b1;
            n_active = (r_steps != COORD_WIDTH'(1));
            n_out.pixel_x     = n_cur_x;
            n_out.pixel_y     = n_cur_y;
            n_out.pixel_valid = 1'b1;
            n_out.last_pixel  = (r_steps == COORD_WIDTH'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_err     <= n_err;
            r_diag    <= n_diag;
            r_axial   <= n_axial;
            r_steps   <= n_steps;
            r_x_neg   <= n_x_neg;
            r_y_neg   <= n_y_neg;
            r_x_major <= n_x_major;
            r_out     <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_active <= n_active;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_active_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps != '0))
        else $error("line active with no steps left");

    a_idle_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.pixel_valid) |->
            (r_out.pixel_x == '0 && r_out.pixel_y == '0 && !r_out.last_pixel))
        else $error("invalid pixel word carries data");

    a_last_step_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_cmd.is_start && r_active && r_steps == COORD_WIDTH'(1)) |=>
            (!r_active && r_out.last_pixel))
        else $error("final step did not end the line");

endmodule

[rtl/bresenham_line_pixel_generator_core.sv]
// Top level of the Bresenham line pixel generator.
//
// Usage:
//   Input queue side: drive i_word and raise push; the word is taken on a
//   clock edge with push high and full low. opcode OP_START begins a line
//   (abandoning any line in progress), OP_STEP asks for the next pixel.
//   Result queue side: while empty is low, o_word holds the oldest pixel
//   word; it is taken on an edge with pop high. A step with no line in
//   progress returns a word with pixel_valid low and all other fields zero.
//   The final endpoint of a line carries last_pixel high.
// Path: a pushed word is registered in the command queue and then in the
//   result register, from which it is popped; the queue has no bypass.
// Throughput: one word per clock while pop stays high, set by the stepper in the
//   back end (one error add and two coordinate updates per word).
// Structure: the front end classifies and computes deltas; a two-word command
//   queue decouples it from the back end, which holds the line state and a
//   one-word result register. When the receiver stalls the result register
//   holds, the command queue fills and then full rises.
// Reset (i_rst_n, synchronous, active low): both queues empty, no line active.
module bresenham_line_pixel_generator_core import blg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_word
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_pop;

    // classify and set up deltas, directions and major axis
    blg_front u_front (
        .i_word (i_word),
        .o_cmd  (front_cmd)
    );

    // short decoupling queue; full here is the input back-pressure
    blg_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // stepper and result register
    blg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_word      (o_word)
    );

endmodule

[tb/sv/bresenham_line_pixel_generator_core_tb.sv]
// Self-checking testbench for the Bresenham line pixel generator core.
`timescale 1ns / 1ps

module bresenham_line_pixel_generator_core_tb;
    import blg_pkg::*;

    localparam int STEP_W      = COORD_WIDTH + 1;
    localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;
    localparam int RAND_WORDS  = 1500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    // Directed stimulus row; res is only used where known is set.
    typedef struct {
        t_in_word  word;
        bit        known;
        t_out_word res;
    } t_table_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_word  = '0;
    logic      full;
    logic      empty;
    t_out_word o_word;

    // Own copy of the line state, updated on every accepted word.
    t_coord                    trace_x     = '0;
    t_coord                    trace_y     = '0;
    logic signed [ERR_WIDTH-1:0] trace_err   = '0;
    logic signed [ERR_WIDTH-1:0] trace_diag  = '0;
    logic signed [ERR_WIDTH-1:0] trace_axial = '0;
    logic [STEP_W-1:0]         trace_left  = '0;
    logic                      trace_xneg  = 1'b0;
    logic                      trace_yneg  = 1'b0;
    logic                      trace_xmaj  = 1'b0;
    logic                      trace_busy  = 1'b0;

    t_out_word  expected_pixels[$];
    t_table_row directed[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    // Set during the stretch where neither side is allowed to idle.
    bit         quiet          = 1'b0;

    bresenham_line_pixel_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word)
    );

    always #5 i_clk = ~i_clk;

    // Pixel predictor: works out the word the block returns for w and
    // advances the tracked line state.
    function automatic t_out_word next_pixel(input t_in_word w);
        t_out_word px;
        int        dx;
        int        dy;
        int        dmaj;
        int        dmin;
        px = '0;
        if (w.opcode == OP_START) begin
            // A start always wins, abandoning whatever line was running.
            dx = int'(w.x_end) - int'(w.x_start);
            dy = int'(w.y_end) - int'(w.y_start);
            trace_xneg = w.x_end < w.x_start;
            trace_yneg = w.y_end < w.y_start;
            if (dx < 0) begin
                dx = -dx;
            end
            if (dy < 0) begin
                dy = -dy;
            end
            // On a tie the y axis is the major one.
            trace_xmaj  = dx > dy;
            dmaj        = trace_xmaj ? dx : dy;
            dmin        = trace_xmaj ? dy : dx;
            trace_err   = ERR_WIDTH'(2 * dmin - dmaj);
            trace_diag  = ERR_WIDTH'(2 * (dmin - dmaj));
            trace_axial = ERR_WIDTH'(2 * dmin);
            trace_left  = STEP_W'(dmaj);
            trace_x     = w.x_start;
            trace_y     = w.y_start;
            // A point line is done on its first pixel.
            trace_busy  = trace_left != 0;
            px = '{trace_x, trace_y, 1'b1, ~trace_busy};
        end else if (trace_busy) begin
            // Non-negative error: diagonal move, the minor axis steps too.
            if (trace_err >= 0) begin
                if (trace_xmaj) begin
                    trace_y = trace_yneg ? trace_y - 1'b1 : trace_y + 1'b1;
                end else begin
                    trace_x = trace_xneg ? trace_x - 1'b1 : trace_x + 1'b1;
                end
                trace_err = trace_err + trace_diag;
            end else begin
                trace_err = trace_err + trace_axial;
            end
            if (trace_xmaj) begin
                trace_x = trace_xneg ? trace_x - 1'b1 : trace_x + 1'b1;
            end else begin
                trace_y = trace_yneg ? trace_y - 1'b1 : trace_y + 1'b1;
            end
            trace_left = trace_left - 1'b1;
            trace_busy = trace_left != 0;
            px = '{trace_x, trace_y, 1'b1, ~trace_busy};
        end
        // Step with no line running: invalid word, all fields zero.
        return px;
    endfunction

    task automatic add_row(input t_opcode op, input int xs, input int ys, input int xe,
                           input int ye, input bit known, input int px, input int py,
                           input int pv, input int pl);
        t_table_row row;
        row.word  = '{op, t_coord'(xs), t_coord'(ys), t_coord'(xe), t_coord'(ye)};
        row.known = known;
        row.res   = '{t_coord'(px), t_coord'(py), 1'(pv), 1'(pl)};
        directed.push_back(row);
    endtask

    // Offers one word, with the odd idle cycle in front, and records its
    // expected pixel once the block has taken it.
    task automatic send_word(input t_in_word w, input bit known, input t_out_word typed);
        t_out_word res;
        if (!quiet && $urandom_range(0, 99) < 9) begin
            repeat ($urandom_range(1, 2)) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (full);
        res = next_pixel(w);
        expected_pixels.push_back(known ? typed : res);
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result side: pop low with a probability of 9 in 100, except while quiet is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every popped word is held against the oldest expectation.
    always @(posedge i_clk) begin : check_pixels
        t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected word expected none actual %h", $time, o_word);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("pixel_x", want.pixel_x, o_word.pixel_x);
                compare_field("pixel_y", want.pixel_y, o_word.pixel_y);
                compare_field("pixel_valid", want.pixel_valid, o_word.pixel_valid);
                compare_field("last_pixel", want.last_pixel, o_word.last_pixel);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_in_word w;
        int       words;
        int       xs;
        int       ys;
        int       xe;
        int       ye;
        int       len;
        int       steps;
        int       pick;
        bit       paused;

        // Step after reset, point lines at both corners, full-width lines,
        // the dx == dy tie, abandonment and a step past the end.
        add_row(OP_STEP,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0);
        add_row(OP_START, 0, 0, 0, 0, 1, 0, 0, 1, 1);
        add_row(OP_STEP,  0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1,
                COORD_MAX, COORD_MAX, 1, 1);
        add_row(OP_START, 0, 0, COORD_MAX, 0, 1, 0, 0, 1, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_START, COORD_MAX, 0, 0, COORD_MAX, 1, COORD_MAX, 0, 1, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_START, 0, COORD_MAX, COORD_MAX, 0, 1, 0, COORD_MAX, 1, 0);
        add_row(OP_START, 10, 10, 13, 11, 1, 10, 10, 1, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_START, 20, 20, 19, 24, 1, 20, 20, 1, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_START, 5, 5, 3, 3, 1, 5, 5, 1, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_word(directed[i].word, directed[i].known, directed[i].res);
        end

        // Hold off until the directed words are all back.
        @(negedge i_clk);
        push <= 1'b0;
        wait_drained();

        // Random part: mostly whole lines with random endpoints, some overrun
        // into idle steps, some cut short by the next start, plus noise.
        words  = 0;
        paused = 1'b0;
        while (words < RAND_WORDS) begin
            quiet = (words >= 600) && (words < 900);
            if (!paused && words >= 750) begin
                paused = 1'b1;
                @(negedge i_clk);
                push <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w = '{t_opcode'($urandom_range(0, 1)),
                      t_coord'($urandom_range(0, COORD_MAX)),
                      t_coord'($urandom_range(0, COORD_MAX)),
                      t_coord'($urandom_range(0, COORD_MAX)),
                      t_coord'($urandom_range(0, COORD_MAX))};
                send_word(w, 1'b0, '0);
                words++;
            end else begin
                xs = $urandom_range(0, COORD_MAX);
                ys = $urandom_range(0, COORD_MAX);
                if ($urandom_range(0, 9) == 0) begin
                    xe = $urandom_range(0, COORD_MAX);
                    ye = $urandom_range(0, COORD_MAX);
                end else begin
                    // Short line; reflect back into range near the edges.
                    xe = xs + int'($urandom_range(0, 24)) - 12;
                    ye = ys + int'($urandom_range(0, 24)) - 12;
                    if (xe < 0 || xe > COORD_MAX) begin
                        xe = 2 * xs - xe;
                    end
                    if (ye < 0 || ye > COORD_MAX) begin
                        ye = 2 * ys - ye;
                    end
                end
                len = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > len) begin
                    len = (ye > ys) ? ye - ys : ys - ye;
                end
                pick = $urandom_range(0, 99);
                if (len > 40) begin
                    steps = $urandom_range(0, 40);
                end else if (pick < 70) begin
                    steps = len;
                end else if (pick < 85) begin
                    steps = len + $urandom_range(1, 3);
                end else begin
                    steps = (len == 0) ? 0 : $urandom_range(0, len - 1);
                end
                w = '{OP_START, t_coord'(xs), t_coord'(ys), t_coord'(xe), t_coord'(ye)};
                send_word(w, 1'b0, '0);
                words++;
                // Steps carry junk in the coordinate fields, which must be ignored.
                repeat (steps) begin
                    w = '{OP_STEP,
                          t_coord'($urandom_range(0, COORD_MAX)),
                          t_coord'($urandom_range(0, COORD_MAX)),
                          t_coord'($urandom_range(0, COORD_MAX)),
                          t_coord'($urandom_range(0, COORD_MAX))};
                    send_word(w, 1'b0, '0);
                    words++;
                end
            end
        end
        quiet = 1'b0;

        @(negedge i_clk);
        push <= 1'b0;
        wait_drained();
        // Allow for any stray word still in flight.
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
rtl/blg_pkg.sv
rtl/blg_front.sv
rtl/blg_cmd_fifo.sv
rtl/blg_back.sv
rtl/bresenham_line_pixel_generator_core.sv
tb/sv/bresenham_line_pixel_generator_core_tb.sv
